// File: sv/tsb_pkg.sv
// Shared types and constants of the text screen buffer with cursor.
package tsb_pkg;

   // Screen geometry limits
   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 24;
   localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(DEPTH);

   // Field and register widths
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int SIZE_W   = COL_W + ROW_W;
   localparam int POS_W    = 11;
   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] FILLER = 8'h5F;
   localparam logic [COL_W-1:0]  RESET_COLUMNS = COL_W'(80);
   localparam logic [ROW_W-1:0]  RESET_ROWS    = ROW_W'(24);
   localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(DEPTH - 1);

   typedef enum logic [OP_W-1:0] {
      OP_HOME    = 3'd0,
      OP_ADVANCE = 3'd1,
      OP_BACK    = 3'd2,
      OP_GOTO    = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_READ    = 3'd5,
      OP_WRITE   = 3'd6,
      OP_NOP     = 3'd7
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMNS = 2'd0,
      CSR_ROWS    = 2'd1,
      CSR_SPARE2  = 2'd2,
      CSR_SPARE3  = 2'd3
   } csr_type;

   // Screen geometry handed to the cursor unit
   typedef struct packed {
      logic [COL_W-1:0] columns;
      logic [ROW_W-1:0] rows;
   } geom_type;

   // Saturate a dimension to 1..maxv
   function automatic logic [COL_W-1:0] clamp_dim(input logic [COL_W-1:0] v,
                                                  input logic [COL_W-1:0] maxv);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = COL_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: sv/tsb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1920,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/tsb_cursor.sv
// Next-cursor computation for every command of the screen buffer.
module tsb_cursor (
   input  tsb_pkg::op_type                  op,
   input  logic signed [tsb_pkg::BYTE_W-1:0] column,
   input  logic signed [tsb_pkg::BYTE_W-1:0] row,
   input  logic [tsb_pkg::ADDR_W-1:0]        cursor,
   input  tsb_pkg::geom_type                 geom,
   output logic [tsb_pkg::ADDR_W-1:0]        cursor_next
);

   localparam int WIDE_W = tsb_pkg::SIZE_W + tsb_pkg::ADDR_W + 1;

   logic [tsb_pkg::SIZE_W-1:0] size;
   logic [WIDE_W-1:0]          inc;
   logic                       col_ok;
   logic                       row_ok;
   logic [tsb_pkg::SIZE_W-1:0] prod;
   logic [WIDE_W-1:0]          target;

   // Screen size and advance candidate
   assign size = tsb_pkg::SIZE_W'(geom.columns) * tsb_pkg::SIZE_W'(geom.rows);
   assign inc  = WIDE_W'(cursor) + WIDE_W'(1);

   // Goto bounds and linear index
   assign col_ok = !column[7] && (column[6:0] < geom.columns);
   assign row_ok = !row[7] && (row[6:0] < {2'b00, geom.rows});
   assign prod   = tsb_pkg::SIZE_W'(row[4:0]) * tsb_pkg::SIZE_W'(geom.columns);
   assign target = WIDE_W'(prod) + WIDE_W'(column[6:0]);

   // Select the new cursor by command
   always_comb begin
      unique case (op)
         tsb_pkg::OP_HOME, tsb_pkg::OP_CLEAR: begin
            cursor_next = '0;
         end
         tsb_pkg::OP_ADVANCE: begin
            cursor_next = (inc >= WIDE_W'(size)) ? '0 : inc[tsb_pkg::ADDR_W-1:0];
         end
         tsb_pkg::OP_BACK: begin
            cursor_next = (cursor != '0) ? cursor - tsb_pkg::ADDR_W'(1) : cursor;
         end
         tsb_pkg::OP_GOTO: begin
            cursor_next = (col_ok && row_ok) ? target[tsb_pkg::ADDR_W-1:0] : '0;
         end
         default: begin
            cursor_next = cursor;
         end
      endcase
   end

endmodule

// File: sv/text_screen_buffer_cursor.sv
// Top level of the character screen buffer with a linear cursor.
//
// Requests arrive on the req_ channel (operation, column, row, data) and are
// taken when req_valid is high and req_stall low. Each request yields exactly
// one response on the rsp_ channel: the byte under the cursor after the
// command and the cursor position. A response is taken when rsp_valid is
// high and rsp_stall low.
// A cursor or cell command updates the cursor and accesses the cell memory
// when taken; the registered memory read goes to the response register once
// that register is free. A clear first sweeps every cell of the memory through
// its single write port, one cell a cycle, with the filler character.
// After reset the same sweep fills the memory; req_stall is
// high meanwhile. The csr_ port takes register writes at any time
// (csr_ready is always high); index 0 is the column count, index 1 the row
// count, both saturating to 1..maximum.
// While rsp_stall holds a response, the next request may be taken; its
// response waits in the memory read stage until the output register frees.
module text_screen_buffer_cursor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tsb_pkg::OP_W-1:0]            req_operation,
   input  logic signed [tsb_pkg::BYTE_W-1:0]   req_column,
   input  logic signed [tsb_pkg::BYTE_W-1:0]   req_row,
   input  logic [tsb_pkg::BYTE_W-1:0]          req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tsb_pkg::BYTE_W-1:0]          rsp_cell_value,
   output logic [tsb_pkg::POS_W-1:0]           rsp_cursor_position,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsb_pkg::COL_W-1:0]           csr_wdata
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_WAIT
   } state_type;

   state_type                   state_ff;
   logic [tsb_pkg::ADDR_W-1:0]  sweep_ff;
   logic [tsb_pkg::ADDR_W-1:0]  cursor_ff;
   logic [tsb_pkg::COL_W-1:0]   cols_ff;
   logic [tsb_pkg::ROW_W-1:0]   rows_ff;
   logic                        fwd_ff;
   logic [tsb_pkg::BYTE_W-1:0]  data_ff;
   logic                        rsp_valid_ff;
   logic [tsb_pkg::BYTE_W-1:0]  rsp_value_ff;
   logic [tsb_pkg::POS_W-1:0]   rsp_cursor_ff;

   tsb_pkg::op_type             op;
   tsb_pkg::geom_type           geom;
   logic [tsb_pkg::ADDR_W-1:0]  cursor_in;
   logic                        accept;
   logic                        sweeping;
   logic                        out_free;
   logic                        ram_we;
   logic [tsb_pkg::ADDR_W-1:0]  ram_waddr;
   logic [tsb_pkg::BYTE_W-1:0]  ram_wdata;
   logic [tsb_pkg::ADDR_W-1:0]  ram_raddr;
   logic [tsb_pkg::BYTE_W-1:0]  ram_rdata;
   logic [tsb_pkg::COL_W-1:0]   cols_clamped;
   logic [tsb_pkg::COL_W-1:0]   rows_clamped;

   assign op       = tsb_pkg::op_type'(req_operation);
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign sweeping = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign geom     = '{columns: cols_ff, rows: rows_ff};

   assign cols_clamped = tsb_pkg::clamp_dim(csr_wdata,
                                            tsb_pkg::COL_W'(tsb_pkg::MAX_COLUMNS));
   assign rows_clamped = tsb_pkg::clamp_dim({2'b00, csr_wdata[tsb_pkg::ROW_W-1:0]},
                                            tsb_pkg::COL_W'(tsb_pkg::MAX_ROWS));

   tsb_cursor u_cursor (
      .op          (op),
      .column      (req_column),
      .row         (req_row),
      .cursor      (cursor_ff),
      .geom        (geom),
      .cursor_next (cursor_in)
   );

   // Sweep fills with filler, a write command stores under the old cursor
   assign ram_we    = sweeping || (accept && (op == tsb_pkg::OP_WRITE));
   assign ram_waddr = sweeping ? sweep_ff : cursor_ff;
   assign ram_wdata = sweeping ? tsb_pkg::FILLER : req_data;
   // Read the new cursor on accept, hold the current one otherwise
   assign ram_raddr = accept ? cursor_in : cursor_ff;

   tsb_ram #(
      .WIDTH (tsb_pkg::BYTE_W),
      .DEPTH (tsb_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Sequencer, registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         cursor_ff    <= '0;
         cols_ff      <= tsb_pkg::RESET_COLUMNS;
         rows_ff      <= tsb_pkg::RESET_ROWS;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Take register writes
         if (csr_valid) begin
            unique case (tsb_pkg::csr_type'(csr_index))
               tsb_pkg::CSR_COLUMNS: cols_ff <= cols_clamped;
               tsb_pkg::CSR_ROWS:    rows_ff <= rows_clamped[tsb_pkg::ROW_W-1:0];
               default: ;
            endcase
         end

         // Drop a response once taken; the wait state reloads it itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_WAIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_INIT, ST_CLEAR: begin
               sweep_ff <= sweep_ff + tsb_pkg::ADDR_W'(1);
               if (sweep_ff == tsb_pkg::LAST_ADDR) begin
                  state_ff <= (state_ff == ST_INIT) ? ST_IDLE : ST_WAIT;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cursor_ff <= cursor_in;
                  fwd_ff    <= (op == tsb_pkg::OP_WRITE);
                  data_ff   <= req_data;
                  sweep_ff  <= '0;
                  state_ff  <= (op == tsb_pkg::OP_CLEAR) ? ST_CLEAR : ST_WAIT;
               end
            end
            ST_WAIT: begin
               // Hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= fwd_ff ? data_ff : ram_rdata;
                  rsp_cursor_ff <= tsb_pkg::POS_W'(cursor_ff);
                  fwd_ff        <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_value_ff;
   assign rsp_cursor_position = rsp_cursor_ff;

endmodule

// File: bench/text_screen_buffer_cursor_tb.sv
// Self-checking testbench of the character screen buffer with a linear cursor.
module text_screen_buffer_cursor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // What one response carries: the byte under the cursor and the cursor
   typedef struct {
      logic [tsb_pkg::BYTE_W-1:0] cell_byte;
      logic [tsb_pkg::POS_W-1:0]  position;
   } screen_view_type;

   // Shadow copy of the screen store and cursor, and the views still owed
   class screen_shadow_type;
      logic [tsb_pkg::BYTE_W-1:0] cells [tsb_pkg::DEPTH];
      int                         cursor;
      int                         columns;
      int                         rows;
      screen_view_type            pending_views [$];
      int                         mismatches;

      function new();
         foreach (cells[i]) cells[i] = tsb_pkg::FILLER;
         cursor     = 0;
         columns    = tsb_pkg::MAX_COLUMNS;
         rows       = tsb_pkg::MAX_ROWS;
         mismatches = 0;
      endfunction

      // Zero reads as one, anything above the maximum saturates
      function int fit_dimension(int value, int top);
         if (value == 0) return 1;
         return (value > top) ? top : value;
      endfunction

      function void write_register(tsb_pkg::csr_type index,
                                   logic [tsb_pkg::COL_W-1:0] value);
         case (index)
            tsb_pkg::CSR_COLUMNS:
               columns = fit_dimension(int'(value), tsb_pkg::MAX_COLUMNS);
            tsb_pkg::CSR_ROWS:
               rows = fit_dimension(int'(value[tsb_pkg::ROW_W-1:0]), tsb_pkg::MAX_ROWS);
            default: ;
         endcase
      endfunction

      // Apply an accepted request and queue the view it must produce
      function void apply_request(tsb_pkg::op_type op,
                                  logic signed [tsb_pkg::BYTE_W-1:0] col,
                                  logic signed [tsb_pkg::BYTE_W-1:0] row,
                                  logic [tsb_pkg::BYTE_W-1:0] data);
         int              screen_size;
         int              c;
         int              r;
         screen_view_type view;
         screen_size = columns * rows;
         c = col;
         r = row;
         case (op)
            tsb_pkg::OP_HOME: cursor = 0;
            tsb_pkg::OP_ADVANCE: begin
               cursor = cursor + 1;
               if (cursor >= screen_size) cursor = 0;
            end
            tsb_pkg::OP_BACK: begin
               if (cursor > 0) cursor = cursor - 1;
            end
            tsb_pkg::OP_GOTO: begin
               if (c < 0 || r < 0 || c >= columns || r >= rows) cursor = 0;
               else cursor = r * columns + c;
            end
            tsb_pkg::OP_CLEAR: begin
               foreach (cells[i]) cells[i] = tsb_pkg::FILLER;
               cursor = 0;
            end
            tsb_pkg::OP_WRITE: begin
               if (cursor < tsb_pkg::DEPTH) cells[cursor] = data;
            end
            default: ;
         endcase
         view.cell_byte = (cursor < tsb_pkg::DEPTH) ? cells[cursor] : '0;
         view.position  = tsb_pkg::POS_W'(cursor);
         pending_views.push_back(view);
      endfunction

      // Compare a response with the oldest view owed
      function void check_response(logic [tsb_pkg::BYTE_W-1:0] cell_byte,
                                   logic [tsb_pkg::POS_W-1:0] position);
         screen_view_type want;
         if (pending_views.size() == 0) begin
            mismatches++;
            $display("%t unexpected response: expected none, actual cell_value %h cursor_position %0d",
                     $time, cell_byte, position);
            return;
         end
         want = pending_views.pop_front();
         if (cell_byte !== want.cell_byte) begin
            mismatches++;
            $display("%t cell_value mismatch: expected %h, actual %h",
                     $time, want.cell_byte, cell_byte);
         end
         if (position !== want.position) begin
            mismatches++;
            $display("%t cursor_position mismatch: expected %0d, actual %0d",
                     $time, want.position, position);
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [tsb_pkg::OP_W-1:0]          req_operation = '0;
   logic signed [tsb_pkg::BYTE_W-1:0] req_column = '0;
   logic signed [tsb_pkg::BYTE_W-1:0] req_row = '0;
   logic [tsb_pkg::BYTE_W-1:0]        req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [tsb_pkg::BYTE_W-1:0]        rsp_cell_value;
   logic [tsb_pkg::POS_W-1:0]         rsp_cursor_position;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tsb_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [tsb_pkg::COL_W-1:0]         csr_wdata = '0;

   screen_shadow_type shadow = new();
   int                send_idle = 0;
   int                recv_idle = 0;
   logic              pressure_go = 1'b0;
   logic              holdoff = 1'b0;

   text_screen_buffer_cursor uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_column          (req_column),
      .req_row             (req_row),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_position (rsp_cursor_position),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("text_screen_buffer_cursor_tb: done, errors");
      $finish;
   end

   // Take responses and stall at random, or hold off during the pressure stretch
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         shadow.check_response(rsp_cell_value, rsp_cursor_position);
      if (holdoff) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // Hold the response channel off long enough for the block to back up
   initial begin
      wait (pressure_go);
      @(posedge clock);
      holdoff <= 1'b1;
      repeat (400) @(posedge clock);
      holdoff <= 1'b0;
   end

   // Write one register and wait for it to be taken
   task automatic write_register(tsb_pkg::csr_type index,
                                 logic [tsb_pkg::COL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.write_register(index, value);
   endtask

   // Set the screen size; the spare indexes must be ignored
   task automatic program_screen(logic [tsb_pkg::COL_W-1:0] columns_raw,
                                 logic [tsb_pkg::COL_W-1:0] rows_raw);
      write_register(tsb_pkg::CSR_COLUMNS, columns_raw);
      write_register(tsb_pkg::CSR_ROWS, rows_raw);
      write_register(tsb_pkg::CSR_SPARE2, tsb_pkg::COL_W'($urandom));
      write_register(tsb_pkg::CSR_SPARE3, tsb_pkg::COL_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Offer one request after a random gap and wait until it is taken
   task automatic send_command(tsb_pkg::op_type op,
                               logic signed [tsb_pkg::BYTE_W-1:0] col,
                               logic signed [tsb_pkg::BYTE_W-1:0] row,
                               logic [tsb_pkg::BYTE_W-1:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_column    <= col;
      req_row       <= row;
      req_data      <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.apply_request(op, col, row, data);
   endtask

   // Weighted random command; most gotos land on the screen
   task automatic send_random_command();
      int                                pick;
      tsb_pkg::op_type                   op;
      logic signed [tsb_pkg::BYTE_W-1:0] col;
      logic signed [tsb_pkg::BYTE_W-1:0] row;
      logic [tsb_pkg::BYTE_W-1:0]        data;
      pick = $urandom_range(99);
      col  = tsb_pkg::BYTE_W'($urandom);
      row  = tsb_pkg::BYTE_W'($urandom);
      data = tsb_pkg::BYTE_W'($urandom);
      if (pick < 5) op = tsb_pkg::OP_HOME;
      else if (pick < 30) op = tsb_pkg::OP_ADVANCE;
      else if (pick < 45) op = tsb_pkg::OP_BACK;
      else if (pick < 65) op = tsb_pkg::OP_GOTO;
      else if (pick < 67) op = tsb_pkg::OP_CLEAR;
      else if (pick < 80) op = tsb_pkg::OP_READ;
      else if (pick < 98) op = tsb_pkg::OP_WRITE;
      else op = tsb_pkg::OP_NOP;
      if (op == tsb_pkg::OP_GOTO && $urandom_range(99) < 80) begin
         col = tsb_pkg::BYTE_W'($urandom_range(shadow.columns - 1));
         row = tsb_pkg::BYTE_W'($urandom_range(shadow.rows - 1));
      end
      send_command(op, col, row, data);
   endtask

   initial begin
      logic [tsb_pkg::COL_W-1:0] columns_raw;
      logic [tsb_pkg::COL_W-1:0] rows_raw;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         // Pick the screen size: saturating, zero, single row, single column, random, random saturating
         case (phase)
            0: begin columns_raw = 7'd127; rows_raw = 7'd31; end
            1: begin columns_raw = 7'd0;   rows_raw = 7'd0;  end
            2: begin columns_raw = 7'd80;  rows_raw = 7'd1;  end
            3: begin columns_raw = 7'd1;   rows_raw = 7'd24; end
            4: begin
               columns_raw = tsb_pkg::COL_W'($urandom_range(79, 2));
               rows_raw    = tsb_pkg::COL_W'($urandom_range(127));
            end
            default: begin
               columns_raw = tsb_pkg::COL_W'($urandom_range(127, 81));
               rows_raw    = tsb_pkg::COL_W'($urandom_range(31, 25)) | 7'h60;
            end
         endcase
         send_idle = (phase < 2) ? 10 : (phase < 4) ? 80 : 0;
         recv_idle = (phase < 2) ? 80 : (phase < 4) ? 10 : 0;
         program_screen(columns_raw, rows_raw);

         if (phase == 0) begin
            // Walk the edges of the full screen, out-of-range gotos, unused code, clear
            send_command(tsb_pkg::OP_HOME, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_WRITE, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_READ, 0, 0, 8'hFF);
            send_command(tsb_pkg::OP_ADVANCE, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_WRITE, 0, 0, 8'hFF);
            send_command(tsb_pkg::OP_BACK, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_BACK, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 79, 23, 8'h00);
            send_command(tsb_pkg::OP_WRITE, 0, 0, 8'hA5);
            send_command(tsb_pkg::OP_ADVANCE, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_READ, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 80, 0, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 0, 24, 8'h00);
            send_command(tsb_pkg::OP_GOTO, -1, 5, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 5, -128, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 127, 127, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 79, 0, 8'h00);
            send_command(tsb_pkg::OP_WRITE, -1, -1, 8'h5A);
            send_command(tsb_pkg::OP_NOP, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 0, 23, 8'h00);
            send_command(tsb_pkg::OP_WRITE, 0, 0, 8'h80);
            send_command(tsb_pkg::OP_CLEAR, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 0, 23, 8'h00);
            send_command(tsb_pkg::OP_READ, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_GOTO, 79, 23, 8'h00);
         end else begin
            // Start off the cursor the last phase left, maybe beyond the new screen
            send_command(tsb_pkg::OP_READ, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_BACK, 0, 0, 8'h00);
            send_command(tsb_pkg::OP_ADVANCE, 0, 0, 8'h00);
         end

         if (phase == 4) pressure_go = 1'b1;
         repeat (250) send_random_command();

         // Park the cursor on the last cell so the next resize strands it
         send_command(tsb_pkg::OP_GOTO, tsb_pkg::BYTE_W'(shadow.columns - 1),
                      tsb_pkg::BYTE_W'(shadow.rows - 1), tsb_pkg::BYTE_W'($urandom));
         req_valid <= 1'b0;
         while (shadow.pending_views.size() != 0) @(posedge clock);
         repeat (8) @(posedge clock);
      end

      // Catch any stray response after the last one owed
      repeat (20) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending_views.size() == 0)
         $display("text_screen_buffer_cursor_tb: done, clean");
      else
         $display("text_screen_buffer_cursor_tb: done, errors");
      $finish;
   end

endmodule
